### rtl/nfi_pkg.sv
// Types, constants and a saturating helper for the Newton forward interpolator.
// Used by newton_forward_interpolator_core; depends on nothing else.
package nfi_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int FIELD_W     = 48;
  localparam int ACC_W       = 64;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int H_W         = FIELD_W + 1;
  localparam int MULT_W      = $clog2(MAX_POINTS);
  localparam int DEN_W       = H_W + MULT_W;
  localparam int NUM_W       = H_W + MULT_W + 1;
  localparam int PROD_W      = 2 * ACC_W;
  localparam int DCNT_W      = $clog2(PROD_W);
  localparam int SPACING_TOL = (1 << FRAC_BITS) / 1000000;

  typedef enum logic {
    FN_LOAD = 1'b0,
    FN_EVAL = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_SPACING = 3'd3,
    ST_SAT     = 3'd4
  } stat_t;

  typedef struct packed {
    func_t                      func;
    logic signed [FIELD_W-1:0]  point_x;
    logic signed [FIELD_W-1:0]  point_y;
    logic signed [FIELD_W-1:0]  query_x;
  } cmd_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  value;
    stat_t                      status;
  } res_t;

  typedef struct packed {
    logic                      ovf;
    logic signed [ACC_W-1:0]   val;
  } sat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_ONE_RD, S_ONE_USE, S_SP_RD, S_SP_USE,
    S_CP_RD, S_CP_USE, S_DF_RD, S_DF_USE, S_HZ_RD, S_HZ_USE, S_MSET, S_MUL,
    S_RND, S_DIV, S_AD_RD, S_AD_USE, S_FIN, S_DONE
  } state_t;

  // Saturating add or subtract on the signed accumulator width.
  function automatic sat_t sat_sum(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b,
                                   input logic sub);
    logic signed [ACC_W:0] r;
    sat_t o;
    r = sub ? (ACC_W+1)'(a) - (ACC_W+1)'(b) : (ACC_W+1)'(a) + (ACC_W+1)'(b);
    o.ovf = r[ACC_W] ^ r[ACC_W-1];
    if (o.ovf) begin
      o.val = r[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      o.val = r[ACC_W-1:0];
    end
    return o;
  endfunction

endpackage

### rtl/newton_forward_interpolator_core.sv
// Newton forward-difference interpolator over a sorted store of sample points.
// Depends on nfi_pkg for the payload structs, state codes and saturating helper.
//
// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid/cmd_ready  | cmd_t: func, point_x, point_y, query_x
// res     | out       | res_valid/res_ready  | res_t: value, status
//
// A load inserts the point in x order by one read and one write of the store per
// step. A load into a full store goes straight to its result with status full.
// An evaluate runs the spacing check and table copy, then the differences, then
// the Horner steps, each with a multiply and a divide by the bit-serial 128-bit
// divider.
// Reset clears the point count and the result valid flag; the stores are not cleared.
// A result that is not taken holds the block in its final state until it is.
module newton_forward_interpolator_core
  import nfi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  cmd_t  cmd,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  state_t state, state_next;

  logic signed [FIELD_W-1:0] xmem [MAX_POINTS];
  logic signed [FIELD_W-1:0] ymem [MAX_POINTS];
  logic signed [ACC_W-1:0]   dmem [MAX_POINTS];
  logic signed [FIELD_W-1:0] rd_x, rd_y;
  logic signed [ACC_W-1:0]   rd_d;

  logic [CNT_W-1:0] count, j, cnt_m1;
  logic [IDX_W-1:0] i, k, addr, waddr;
  cmd_t             cur;
  logic signed [FIELD_W-1:0] prevx;
  logic signed [H_W-1:0]     h, gap;
  logic signed [H_W:0]       dev;
  logic [DEN_W-1:0]          den;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          num_mag;
  logic signed [ACC_W-1:0]   prevd, acc, md;
  logic                      sat, neg;
  logic [ACC_W-1:0]          ua, ub, mq;
  logic [PROD_W-1:0]         prod;
  logic [1:0]                mcnt;
  logic [31:0]               ma, mb;
  logic [63:0]               pp;
  logic [PROD_W-1:0]         pp_sh;
  logic [DEN_W-1:0]          rem;
  logic [DEN_W:0]            dt;
  logic                      dge, qovf, sp_err, ins_gt, last_j;
  logic [ACC_W-1:0]          q;
  logic [DCNT_W-1:0]         dcnt;
  logic signed [FIELD_W-1:0] rvalue;
  stat_t                     rstat;
  logic                      we_xy, we_d, res_load;
  logic signed [FIELD_W-1:0] wx, wy;
  logic signed [ACC_W-1:0]   wd;
  sat_t                      dsub, hsum;

  assign cnt_m1  = count - CNT_W'(1);
  assign last_j  = (j == cnt_m1);
  assign ins_gt  = (rd_x > cur.point_x);
  assign gap     = H_W'(rd_x) - H_W'(prevx);
  assign dev     = (H_W+1)'(gap) - (H_W+1)'(h);
  assign sp_err  = (gap == '0) || (j == CNT_W'(1)) ? (gap == '0)
                 : (dev > (H_W+1)'(SPACING_TOL)) || (dev < -(H_W+1)'(SPACING_TOL));
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dsub    = sat_sum(rd_d, prevd, 1'b1);
  assign mq      = (qovf || q[ACC_W-1]) ? {1'b0, {(ACC_W-1){1'b1}}} : q;
  assign md      = neg ? -$signed(mq) : $signed(mq);
  assign hsum    = sat_sum(rd_d, md, 1'b0);
  assign ma      = mcnt[0] ? ua[63:32] : ua[31:0];
  assign mb      = mcnt[1] ? ub[63:32] : ub[31:0];
  assign pp      = ma * mb;
  assign dt      = {rem, prod[PROD_W-1]};
  assign dge     = (dt >= {1'b0, den});
  assign res_load = (state == S_DONE) && (!res_valid || res_ready);

  always_comb begin
    case (mcnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.func == FN_LOAD) begin
            state_next = (count == CNT_W'(MAX_POINTS)) ? S_DONE : S_INS_RD;
          end else if (count == '0) begin
            state_next = S_DONE;
          end else if (count == CNT_W'(1)) begin
            state_next = S_ONE_RD;
          end else begin
            state_next = S_SP_RD;
          end
        end
      end
      S_INS_RD:  state_next = (j == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP: state_next = ins_gt ? S_INS_RD : S_DONE;
      S_ONE_RD:  state_next = S_ONE_USE;
      S_ONE_USE: state_next = S_DONE;
      S_SP_RD:   state_next = S_SP_USE;
      S_SP_USE: begin
        if (j != '0 && sp_err) begin
          state_next = S_DONE;
        end else begin
          state_next = last_j ? S_CP_RD : S_SP_RD;
        end
      end
      S_CP_RD:   state_next = S_CP_USE;
      S_CP_USE:  state_next = last_j ? S_DF_RD : S_CP_RD;
      S_DF_RD:   state_next = S_DF_USE;
      S_DF_USE: begin
        if (j != CNT_W'(i) && last_j && CNT_W'(i) == count - CNT_W'(2)) begin
          state_next = S_HZ_RD;
        end else begin
          state_next = S_DF_RD;
        end
      end
      S_HZ_RD:   state_next = S_HZ_USE;
      S_HZ_USE:  state_next = S_MSET;
      S_MSET:    state_next = S_MUL;
      S_MUL:     state_next = (mcnt == 2'd3) ? S_RND : S_MUL;
      S_RND:     state_next = S_DIV;
      S_DIV:     state_next = (dcnt == DCNT_W'(PROD_W - 1)) ? S_AD_RD : S_DIV;
      S_AD_RD:   state_next = S_AD_USE;
      S_AD_USE:  state_next = (k == IDX_W'(1)) ? S_FIN : S_MSET;
      S_FIN:     state_next = S_DONE;
      S_DONE:    state_next = res_load ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == S_IDLE);
    addr      = j[IDX_W-1:0];
    waddr     = j[IDX_W-1:0];
    we_xy     = 1'b0;
    we_d      = 1'b0;
    wx        = cur.point_x;
    wy        = cur.point_y;
    wd        = dsub.val;
    case (state)
      S_INS_RD: begin
        addr  = j[IDX_W-1:0] - IDX_W'(1);
        we_xy = (j == '0);
      end
      S_INS_CMP: begin
        we_xy = 1'b1;
        if (ins_gt) begin
          wx = rd_x;
          wy = rd_y;
        end
      end
      S_ONE_RD: addr = '0;
      S_CP_USE: begin
        we_d = 1'b1;
        wd   = ACC_W'(rd_y);
      end
      S_DF_USE: we_d = (j != CNT_W'(i));
      S_HZ_RD:  addr = cnt_m1[IDX_W-1:0];
      S_AD_RD:  addr = k - IDX_W'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_x <= xmem[addr];
    rd_y <= ymem[addr];
    rd_d <= dmem[addr];
    if (we_xy) begin
      xmem[waddr] <= wx;
      ymem[waddr] <= wy;
    end
    if (we_d) begin
      dmem[waddr] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (res_load && cur.func == FN_EVAL) begin
        count <= '0;
      end else if ((state == S_INS_RD && j == '0) || (state == S_INS_CMP && !ins_gt)) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur    <= cmd;
        j      <= (cmd.func == FN_LOAD) ? count : '0;
        sat    <= 1'b0;
        rvalue <= '0;
        if (cmd.func == FN_LOAD) begin
          rstat <= (count == CNT_W'(MAX_POINTS)) ? ST_FULL : ST_OK;
        end else begin
          rstat <= (count == '0) ? ST_EMPTY : ST_OK;
        end
      end
      S_INS_CMP: j <= j - CNT_W'(1);
      S_ONE_USE: rvalue <= rd_y;
      S_SP_USE: begin
        prevx <= rd_x;
        j     <= last_j ? '0 : j + CNT_W'(1);
        if (j == '0) begin
        end else if (j == CNT_W'(1)) begin
          h   <= gap;
          den <= DEN_W'(gap);
          num <= NUM_W'(cur.query_x) - NUM_W'(prevx);
        end else begin
          den <= den + DEN_W'(h);
          num <= num - NUM_W'(h);
        end
        if (j != '0 && sp_err) begin
          rstat <= ST_SPACING;
        end
      end
      S_CP_USE: begin
        j <= last_j ? '0 : j + CNT_W'(1);
        i <= '0;
      end
      S_DF_USE: begin
        prevd <= rd_d;
        if (j != CNT_W'(i)) begin
          sat <= sat | dsub.ovf;
        end
        if (j != CNT_W'(i) && last_j) begin
          i <= i + IDX_W'(1);
          j <= CNT_W'(i) + CNT_W'(1);
        end else begin
          j <= j + CNT_W'(1);
        end
        k <= cnt_m1[IDX_W-1:0];
      end
      S_HZ_USE: acc <= rd_d;
      S_MSET: begin
        ua   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        ub   <= ACC_W'(num_mag);
        neg  <= acc[ACC_W-1] ^ num[NUM_W-1];
        prod <= '0;
        mcnt <= '0;
      end
      S_MUL: begin
        prod <= prod + pp_sh;
        mcnt <= mcnt + 2'd1;
      end
      S_RND: begin
        prod <= prod + PROD_W'(den >> 1);
        rem  <= '0;
        q    <= '0;
        qovf <= 1'b0;
        dcnt <= '0;
      end
      S_DIV: begin
        rem  <= dge ? DEN_W'(dt - {1'b0, den}) : dt[DEN_W-1:0];
        q    <= {q[ACC_W-2:0], dge};
        qovf <= qovf | q[ACC_W-1];
        prod <= {prod[PROD_W-2:0], 1'b0};
        dcnt <= dcnt + DCNT_W'(1);
      end
      S_AD_USE: begin
        acc <= hsum.val;
        sat <= sat | hsum.ovf | qovf | q[ACC_W-1];
        k   <= k - IDX_W'(1);
        den <= den - DEN_W'(h);
        num <= num + NUM_W'(h);
      end
      S_FIN: begin
        if (acc > $signed({{(ACC_W-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}})) begin
          rvalue <= {1'b0, {(FIELD_W-1){1'b1}}};
          rstat  <= ST_SAT;
        end else if (acc < $signed({{(ACC_W-FIELD_W+1){1'b1}}, {(FIELD_W-1){1'b0}}})) begin
          rvalue <= {1'b1, {(FIELD_W-1){1'b0}}};
          rstat  <= ST_SAT;
        end else begin
          rvalue <= acc[FIELD_W-1:0];
          rstat  <= sat ? ST_SAT : ST_OK;
        end
      end
      default: begin
      end
    endcase
    if (res_load) begin
      res.value  <= rvalue;
      res.status <= rstat;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond the store");

  a_eval_clears: assert property (@(posedge clk) disable iff (rst)
    (res_load && cur.func == FN_EVAL) |=> (count == '0))
    else $error("evaluate did not consume the point set");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0) && (rem < den))
    else $error("divider remainder out of range");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid && cmd.func == FN_LOAD && count == CNT_W'(MAX_POINTS))
    |=> (count == $past(count)))
    else $error("dropped load changed the point count");
`endif

endmodule
